// ----- rtl/core/ocrt_pkg.sv -----
package ocrt_pkg;

	localparam int unsigned LADDER_BASE   = 18969;
	localparam int unsigned LADDER_STRIDE = 880;
	localparam int unsigned RUNG_IDX_W    = 5;

	localparam int unsigned CUR_W  = 10;
	localparam int unsigned POS_W  = 16;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// register index, taken from paddr[4:2]
	typedef enum logic [2:0] {
		REG_OVER_CURRENT_LIMIT = 3'd0,
		REG_LOWER_LIMIT_FIRST  = 3'd1,
		REG_LOWER_LIMIT_SECOND = 3'd2,
		REG_UPPER_LIMIT_FIRST  = 3'd3,
		REG_UPPER_LIMIT_SECOND = 3'd4
	} reg_idx_t;

	localparam logic [CUR_W-1:0] OCL_RESET = 10'd800;
	localparam logic [POS_W-1:0] LD_RESET  = 16'd18969;
	localparam logic [POS_W-1:0] LU_RESET  = 16'd28649;

	typedef struct packed {
		logic [CUR_W-1:0] current_first;
		logic [CUR_W-1:0] current_second;
		logic [POS_W-1:0] position_first;
		logic [POS_W-1:0] position_second;
		logic [POS_W-1:0] pair_offset;
		logic             running_normal;
		logic             external_trip;
		logic             no_fault;
		logic             clear_trips;
	} item_t;

	function automatic logic [POS_W-1:0] rung_at(input logic [RUNG_IDX_W-1:0] k);
		return POS_W'(LADDER_BASE + LADDER_STRIDE * 32'(k));
	endfunction

endpackage

// ----- rtl/core/overcurrent_retreat_target_core.sv -----
// Overcurrent trip detector for a motor pair, with retreat targets.
//
// Input channel (in_valid / in_stall) carries one sample set per request:
// two currents, two hall positions, the signed pair offset and state flags.
// Output channel (out_valid / out_stall) returns one result per request:
// trip indication, go_back, the held retreat targets and the latched flags.
// The sample sits in an input register, then in the result register; one
// request is taken every cycle while in_stall is low. The ladder compare,
// clamp and offset arithmetic run in one combinational pass, and the trip
// flags, goals and result register load together when the input register
// advances, so each request sees the state left by the one before it.
// When out_stall is high the result is held and one more request may sit in
// the input register; in_stall rises only once both are full.
// Reset clears the trip flags and goals to zero, empties both stages and
// loads the limit registers with their defaults. Limits must be written over
// the APB port only while no request is in flight, not enforced by the block.
module overcurrent_retreat_target_core #(
	parameter int LADDER_STEPS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ocrt_pkg::ADDR_W-1:0]  paddr,
	input  logic [ocrt_pkg::DATA_W-1:0]  pwdata,
	output logic [ocrt_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,

	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ocrt_pkg::CUR_W-1:0]   current_first,
	input  logic [ocrt_pkg::CUR_W-1:0]   current_second,
	input  logic [ocrt_pkg::POS_W-1:0]   position_first,
	input  logic [ocrt_pkg::POS_W-1:0]   position_second,
	input  logic signed [ocrt_pkg::POS_W-1:0] pair_offset,
	input  logic                         running_normal,
	input  logic                         external_trip,
	input  logic                         no_fault,
	input  logic                         clear_trips,

	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         tripped_now,
	output logic                         go_back,
	output logic [ocrt_pkg::POS_W-1:0]   target_first,
	output logic [ocrt_pkg::POS_W-1:0]   target_second,
	output logic                         latched_first,
	output logic                         latched_second
);
	import ocrt_pkg::*;

	localparam logic [POS_W-1:0] RUNG0 = rung_at(RUNG_IDX_W'(0));
	localparam logic [POS_W-1:0] TOP   = rung_at(RUNG_IDX_W'(LADDER_STEPS - 1));

	// configuration
	logic [CUR_W-1:0] ocl_q;
	logic [POS_W-1:0] ld1_q, ld2_q, lu1_q, lu2_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocl_q <= OCL_RESET;
			ld1_q <= LD_RESET;
			ld2_q <= LD_RESET;
			lu1_q <= LU_RESET;
			lu2_q <= LU_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_OVER_CURRENT_LIMIT: ocl_q <= pwdata[CUR_W-1:0];
				REG_LOWER_LIMIT_FIRST:  ld1_q <= pwdata[POS_W-1:0];
				REG_LOWER_LIMIT_SECOND: ld2_q <= pwdata[POS_W-1:0];
				REG_UPPER_LIMIT_FIRST:  lu1_q <= pwdata[POS_W-1:0];
				REG_UPPER_LIMIT_SECOND: lu2_q <= pwdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_OVER_CURRENT_LIMIT: prdata = DATA_W'(ocl_q);
			REG_LOWER_LIMIT_FIRST:  prdata = DATA_W'(ld1_q);
			REG_LOWER_LIMIT_SECOND: prdata = DATA_W'(ld2_q);
			REG_UPPER_LIMIT_FIRST:  prdata = DATA_W'(lu1_q);
			REG_UPPER_LIMIT_SECOND: prdata = DATA_W'(lu2_q);
			default:                prdata = '0;
		endcase
	end

	// handshake
	logic  valid_s1;
	item_t item_s1;
	logic  out_adv, s1_adv, in_acc;

	assign out_adv  = !out_valid || !out_stall;
	assign s1_adv   = valid_s1 && out_adv;
	assign in_stall = valid_s1 && !out_adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc || s1_adv) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= '{current_first:   current_first,
			             current_second:  current_second,
			             position_first:  position_first,
			             position_second: position_second,
			             pair_offset:     pair_offset,
			             running_normal:  running_normal,
			             external_trip:   external_trip,
			             no_fault:        no_fault,
			             clear_trips:     clear_trips};
		end
	end

	// state
	logic             flag1_q, flag2_q;
	logic [POS_W-1:0] goal1_q, goal2_q;

	// detection
	logic detect, t1, t2, trip;

	assign detect = item_s1.running_normal && !flag1_q && !flag2_q;
	assign t1     = (item_s1.current_first > ocl_q) || item_s1.external_trip;
	assign t2     = (item_s1.current_second > ocl_q) || item_s1.external_trip;
	assign trip   = detect && (t1 || t2);

	// retreat: with a negative offset the motors swap roles and the offset is negated
	logic             neg;
	logic [POS_W-1:0] m, p_hi, p_lo, offv, ld_hi, ld_lo, lu_hi, prev_hi, prev_lo;
	logic [POS_W-1:0] g_hi, g_lo, glo_a, ghi_a, sel;
	logic             found;
	logic [POS_W-1:0] goal1_d, goal2_d;

	assign neg     = item_s1.pair_offset[POS_W-1];
	assign m       = (item_s1.position_first > item_s1.position_second) ?
	                 item_s1.position_second : item_s1.position_first;
	assign p_hi    = neg ? item_s1.position_second : item_s1.position_first;
	assign p_lo    = neg ? item_s1.position_first  : item_s1.position_second;
	assign offv    = neg ? POS_W'(~item_s1.pair_offset + 1'b1) : item_s1.pair_offset;
	assign ld_hi   = neg ? ld2_q : ld1_q;
	assign ld_lo   = neg ? ld1_q : ld2_q;
	assign lu_hi   = neg ? lu2_q : lu1_q;
	assign prev_hi = neg ? goal2_q : goal1_q;
	assign prev_lo = neg ? goal1_q : goal2_q;

	// rung just below the first rung at or above m, scanned from the top so the lowest wins
	always_comb begin
		sel   = RUNG0;
		found = 1'b0;
		for (int k = LADDER_STEPS - 1; k >= 1; k--) begin
			if (rung_at(RUNG_IDX_W'(k)) >= m) begin
				sel   = rung_at(RUNG_IDX_W'(k - 1));
				found = 1'b1;
			end
		end
	end

	assign glo_a = POS_W'(p_lo - POS_W'(p_hi - TOP));
	assign ghi_a = POS_W'(sel + offv);

	always_comb begin
		g_hi = prev_hi;
		g_lo = prev_lo;
		if (RUNG0 > m) begin
			g_lo = ld_lo;
			g_hi = POS_W'(ld_hi + offv);
		end else if (p_hi >= TOP) begin
			if (glo_a < ld_lo) begin
				g_lo = ld_lo;
				g_hi = POS_W'(p_hi - POS_W'(p_lo - ld_lo));
			end else begin
				g_lo = glo_a;
				g_hi = TOP;
			end
		end else if (found) begin
			if (ghi_a > lu_hi) begin
				g_lo = ld_lo;
				g_hi = POS_W'(ld_hi + offv);
			end else begin
				g_lo = sel;
				g_hi = ghi_a;
			end
		end
	end

	assign goal1_d = trip ? (neg ? g_lo : g_hi) : goal1_q;
	assign goal2_d = trip ? (neg ? g_hi : g_lo) : goal2_q;

	logic flag1_d, flag2_d;

	always_comb begin
		flag1_d = flag1_q;
		flag2_d = flag2_q;
		if (trip) begin
			flag1_d = t1;
			flag2_d = t2;
		end
		if (item_s1.clear_trips) begin
			flag1_d = 1'b0;
			flag2_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag1_q <= 1'b0;
			flag2_q <= 1'b0;
			goal1_q <= '0;
			goal2_q <= '0;
		end else if (s1_adv) begin
			flag1_q <= flag1_d;
			flag2_q <= flag2_d;
			goal1_q <= goal1_d;
			goal2_q <= goal2_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_adv) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			tripped_now    <= trip;
			go_back        <= trip && item_s1.no_fault;
			target_first   <= goal1_d;
			target_second  <= goal2_d;
			latched_first  <= flag1_d;
			latched_second <= flag2_d;
		end
	end

	// a latched flag blocks any new trip
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && (flag1_q || flag2_q)) |=> !tripped_now)
		else $error("trip reported while a flag was latched");

	// goals move only on a trip
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_adv && trip) |=> ($stable(goal1_q) && $stable(goal2_q)))
		else $error("goal changed without a trip");

	// a held request in the input register survives an output stall
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |=> valid_s1)
		else $error("request lost from input register");

	// a result appears only from a filled input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a request");

endmodule
